// ===== hw/rtl/euc_bph_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euc_bph_pkg
// Shared types and constants for the EUC byte-pair histogram block.
// ----------------------------------------------------------------------------
package euc_bph_pkg;

  localparam int NUM_BINS    = 94;
  localparam int BIN_AW      = 7;
  localparam int CNT_OUT_W   = 32;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 104;
  localparam int OUTQ_DEPTH  = 3;

  localparam logic [7:0] FIRST_CODE = 8'hA1;
  localparam logic [7:0] BAD_CODE   = 8'hFF;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_STOP  = 2'd1,
    PH_TRAIL = 2'd2
  } phase_t;

  // request to the bin store, issued with the item
  typedef struct packed {
    logic              vld;
    logic              rd;     // return both bins at addr
    logic              inc;    // increment one bin at addr
    logic              trail;  // increment targets the trail histogram
    logic [BIN_AW-1:0] addr;
  } bin_req_t;

  // one result item, last field in the low bits
  typedef struct packed {
    logic [CNT_OUT_W-1:0] trail_count;
    logic [CNT_OUT_W-1:0] lead_count;
    logic [CNT_OUT_W-1:0] total_count;
    logic                 sampling_ok;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

// ===== hw/rtl/euc_byte_pair_histogram_top.sv =====
`timescale 1ns / 1ps
// A result item is held in the stage-one registers, then pushed into the output queue, which drives it.
// Throughput: 1 item per cycle while the output queue has room; each bin RAM does one read and one write-back
// per cycle, with a bypass for an increment of the bin just written.
// Reset: phase, total and bin valid flags clear at once; no clearing pass,
// the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
// euc_byte_pair_histogram_top
// EUC double-byte shape checker with lead and trail byte histograms.
// ----------------------------------------------------------------------------
module euc_byte_pair_histogram_top import euc_bph_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], bin_index[14:8]
  input  logic [0:0]             in_tuser,   // op[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // sampling_ok[0], total_count[32:1],
                                             // lead_count[64:33], trail_count[96:65]
);

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic                   s1_v_r;
  logic                   s1_ok_r;
  logic [COUNT_WIDTH-1:0] s1_total_r;

  op_t                    op;
  logic [7:0]             din_byte;
  logic [BIN_AW-1:0]      bin_index;
  logic                   acc, feed, code_bad, code_high;
  logic [BIN_AW-1:0]      code_bin;
  bin_req_t               req;
  logic [COUNT_WIDTH-1:0] lead_count, trail_count;
  logic [1:0]             q_count;
  res_t                   res;

  assign op        = op_t'(in_tuser[0]);
  assign din_byte  = in_tdata[7:0];
  assign bin_index = in_tdata[14:8];
  assign acc       = in_tvalid && in_tready;
  // saturated once the top bit of total is set
  assign feed      = acc && (op == OP_FEED) && !total_r[COUNT_WIDTH-1];
  assign code_high = din_byte[7];
  assign code_bad  = (din_byte == BAD_CODE) || (din_byte < FIRST_CODE);
  assign code_bin  = BIN_AW'(din_byte - FIRST_CODE);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (feed) begin
      case (phase_r)
        PH_LEAD: begin
          if (code_high) begin
            phase_nxt = code_bad ? PH_STOP : PH_TRAIL;
          end
        end
        PH_TRAIL: begin
          phase_nxt = (code_high && !code_bad) ? PH_LEAD : PH_STOP;
        end
        PH_STOP: begin
          phase_nxt = PH_STOP;
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase
    end
  end

  // bin request and total
  always_comb begin
    req       = '0;
    req.vld   = acc;
    total_nxt = total_r;
    if (acc && (op == OP_READ)) begin
      req.rd   = (bin_index < BIN_AW'(NUM_BINS));
      req.addr = req.rd ? bin_index : '0;
    end
    if (feed && code_high && !code_bad &&
        ((phase_r == PH_LEAD) || (phase_r == PH_TRAIL))) begin
      req.inc   = 1'b1;
      req.trail = (phase_r == PH_TRAIL);
      req.addr  = code_bin;
      total_nxt = total_r + COUNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      total_r <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      total_r <= total_nxt;
      s1_v_r  <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ok_r    <= (phase_nxt == PH_LEAD) || (phase_nxt == PH_TRAIL);
      s1_total_r <= total_nxt;
    end
  end

  euc_bph_bins #(.COUNT_WIDTH(COUNT_WIDTH)) u_bins (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (req),
    .lead_count  (lead_count),
    .trail_count (trail_count)
  );

  always_comb begin
    res.sampling_ok = s1_ok_r;
    res.total_count = CNT_OUT_W'(s1_total_r);
    res.lead_count  = CNT_OUT_W'(lead_count);
    res.trail_count = CNT_OUT_W'(trail_count);
  end

  euc_bph_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (s1_v_r),
    .push_data  (res),
    .count      (q_count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // items in flight must fit the queue
  assign in_tready = (3'({1'b0, s1_v_r}) + 3'(q_count)) < 3'(OUTQ_DEPTH);

endmodule

// ===== hw/rtl/euc_bph_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euc_bph_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module euc_bph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 94
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/euc_bph_bins.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euc_bph_bins
// Lead and trail histograms: read in the accept cycle, modify and write back
// in the next cycle, with a one-deep bypass for back-to-back hits.
// ----------------------------------------------------------------------------
module euc_bph_bins import euc_bph_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bin_req_t               req,
  output logic [COUNT_WIDTH-1:0] lead_count,
  output logic [COUNT_WIDTH-1:0] trail_count
);

  bin_req_t                req_r;
  logic [NUM_BINS-1:0]     lead_vld_r, lead_vld_nxt;
  logic [NUM_BINS-1:0]     trail_vld_r, trail_vld_nxt;
  logic                    fwd_we_r;
  logic                    fwd_trail_r;
  logic [BIN_AW-1:0]       fwd_addr_r;
  logic [COUNT_WIDTH-1:0]  fwd_data_r;

  logic [COUNT_WIDTH-1:0]  lead_q, trail_q;
  logic [COUNT_WIDTH-1:0]  lead_cur, trail_cur, new_val;
  logic                    lead_we, trail_we;
  logic                    fwd_hit;

  euc_bph_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_lead_ram (
    .clk   (clk),
    .we    (lead_we),
    .waddr (req_r.addr),
    .wdata (new_val),
    .raddr (req.addr),
    .rdata (lead_q)
  );

  euc_bph_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_BINS)) u_trail_ram (
    .clk   (clk),
    .we    (trail_we),
    .waddr (req_r.addr),
    .wdata (new_val),
    .raddr (req.addr),
    .rdata (trail_q)
  );

  // the write issued at the edge of our read is not seen by the RAM output
  assign fwd_hit = fwd_we_r && (fwd_addr_r == req_r.addr);

  always_comb begin
    lead_cur  = lead_vld_r[req_r.addr] ? lead_q : '0;
    trail_cur = trail_vld_r[req_r.addr] ? trail_q : '0;
    if (fwd_hit && !fwd_trail_r) begin
      lead_cur = fwd_data_r;
    end
    if (fwd_hit && fwd_trail_r) begin
      trail_cur = fwd_data_r;
    end
    new_val  = (req_r.trail ? trail_cur : lead_cur) + COUNT_WIDTH'(1);
    lead_we  = req_r.vld && req_r.inc && !req_r.trail;
    trail_we = req_r.vld && req_r.inc && req_r.trail;

    lead_vld_nxt  = lead_vld_r;
    trail_vld_nxt = trail_vld_r;
    if (lead_we) begin
      lead_vld_nxt[req_r.addr] = 1'b1;
    end
    if (trail_we) begin
      trail_vld_nxt[req_r.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= '0;
      lead_vld_r  <= '0;
      trail_vld_r <= '0;
      fwd_we_r    <= 1'b0;
      fwd_trail_r <= 1'b0;
      fwd_addr_r  <= '0;
    end else begin
      req_r       <= req;
      lead_vld_r  <= lead_vld_nxt;
      trail_vld_r <= trail_vld_nxt;
      fwd_we_r    <= lead_we || trail_we;
      fwd_trail_r <= trail_we;
      fwd_addr_r  <= req_r.addr;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= new_val;
  end

  assign lead_count  = (req_r.vld && req_r.rd) ? lead_cur : '0;
  assign trail_count = (req_r.vld && req_r.rd) ? trail_cur : '0;

endmodule

// ===== hw/rtl/euc_bph_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euc_bph_outq
// Three-entry result queue that drives the output stream.
// ----------------------------------------------------------------------------
module euc_bph_outq import euc_bph_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  res_t                   push_data,
  output logic [1:0]             count,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  res_t       mem_r [OUTQ_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop = out_tvalid && out_tready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : wr_ptr_r + 2'd1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == 2'(OUTQ_DEPTH - 1)) ? 2'd0 : rd_ptr_r + 2'd1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign count      = cnt_r;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = OUT_TDATA_W'(mem_r[rd_ptr_r]);

endmodule

// ===== hw/rtl/euc_bph_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euc_bph_chk
// Port-level checks on the result stream of the byte-pair histogram.
// ----------------------------------------------------------------------------
module euc_bph_chk import euc_bph_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic                 out_acc;
  logic                 stop_seen_r, stop_seen_nxt;
  logic [CNT_OUT_W-1:0] last_total_r, last_total_nxt;
  logic [CNT_OUT_W-1:0] total_f, lead_f, trail_f, limit;

  assign out_acc = out_tvalid && out_tready;
  assign total_f = out_tdata[32:1];
  assign lead_f  = out_tdata[64:33];
  assign trail_f = out_tdata[96:65];
  assign limit   = CNT_OUT_W'(64'd1 << (COUNT_WIDTH - 1));

  always_comb begin
    stop_seen_nxt  = stop_seen_r;
    last_total_nxt = last_total_r;
    if (out_acc) begin
      stop_seen_nxt  = stop_seen_r || !out_tdata[0];
      last_total_nxt = total_f;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_seen_r  <= 1'b0;
      last_total_r <= '0;
    end else begin
      stop_seen_r  <= stop_seen_nxt;
      last_total_r <= last_total_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && stop_seen_r |-> !out_tdata[0])
    else $error("sampling resumed after a shape error");

  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (total_f >= last_total_r) && (total_f <= limit))
    else $error("total went down or past its limit");

  a_bin_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (lead_f <= total_f) && (trail_f <= total_f))
    else $error("bin count above total");

endmodule

bind euc_byte_pair_histogram_top euc_bph_chk #(.COUNT_WIDTH(COUNT_WIDTH)) u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
